>>> design/team_color_tint_argb4444_core_defines.svh
// ----------------------------------------------------------------------------
// team_color_tint_argb4444_core_defines.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef TEAM_COLOR_TINT_ARGB4444_CORE_DEFINES_SVH
`define TEAM_COLOR_TINT_ARGB4444_CORE_DEFINES_SVH

// Check a property while out of reset.
`define TCTA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every edge, reset included.
`define TCTA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/tcta_pkg.sv
// ----------------------------------------------------------------------------
// tcta_pkg
// Types and constants of the team color tint block.
// ----------------------------------------------------------------------------
package tcta_pkg;

   localparam int LANES       = 4;
   localparam int PIXEL_W     = 16;
   localparam int NIBBLE_W    = 4;
   localparam int CSR_INDEX_W = 2;

   localparam int FLAG_BIT    = 12;
   localparam logic [NIBBLE_W-1:0] NIBBLE_MAX = 4'hF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TINT_RED   = 2'd0,
      CSR_TINT_GREEN = 2'd1,
      CSR_TINT_BLUE  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [NIBBLE_W-1:0] red;
      logic [NIBBLE_W-1:0] green;
      logic [NIBBLE_W-1:0] blue;
   } tint_type;

   typedef struct packed {
      logic               flagged;
      logic [PIXEL_W-1:0] tinted;
      logic [PIXEL_W-1:0] marked;
      logic [PIXEL_W-1:0] original;
   } lane_result_type;

endpackage

>>> design/tcta_if.sv
// ----------------------------------------------------------------------------
// tcta_if
// Channel interfaces: pixel group request, result and register write.
// ----------------------------------------------------------------------------
interface tcta_req_if;
   logic                        valid;
   logic                        ready;
   logic [tcta_pkg::PIXEL_W-1:0] pixel0;
   logic [tcta_pkg::PIXEL_W-1:0] pixel1;
   logic [tcta_pkg::PIXEL_W-1:0] pixel2;
   logic [tcta_pkg::PIXEL_W-1:0] pixel3;
   logic                        last_group;

   modport source (output valid, pixel0, pixel1, pixel2, pixel3, last_group, input ready);
   modport sink (input valid, pixel0, pixel1, pixel2, pixel3, last_group, output ready);
endinterface

interface tcta_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tcta_pkg::PIXEL_W-1:0] out_pixel0;
   logic [tcta_pkg::PIXEL_W-1:0] out_pixel1;
   logic [tcta_pkg::PIXEL_W-1:0] out_pixel2;
   logic [tcta_pkg::PIXEL_W-1:0] out_pixel3;
   logic                        out_last;

   modport source (output valid, out_pixel0, out_pixel1, out_pixel2, out_pixel3, out_last,
                   input ready);
   modport sink (input valid, out_pixel0, out_pixel1, out_pixel2, out_pixel3, out_last,
                 output ready);
endinterface

interface tcta_csr_if;
   logic                             valid;
   logic                             ready;
   logic [tcta_pkg::CSR_INDEX_W-1:0] index;
   logic [tcta_pkg::NIBBLE_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> design/tcta_lane.sv
// ----------------------------------------------------------------------------
// tcta_lane
// One pixel lane: flag detect, tinted pixel and alpha-marked pixel.
// ----------------------------------------------------------------------------
module tcta_lane (
   input  logic [tcta_pkg::PIXEL_W-1:0] pixel,
   input  tcta_pkg::tint_type           tint,
   output tcta_pkg::lane_result_type    result
);

   // k*(a&14) + c*16, saturated at 255, keep the upper nibble
   function automatic logic [tcta_pkg::NIBBLE_W-1:0] tint_nibble(
      input logic [tcta_pkg::NIBBLE_W-1:0] k,
      input logic [tcta_pkg::NIBBLE_W-1:0] a,
      input logic [tcta_pkg::NIBBLE_W-1:0] c
   );
      logic [8:0] sum;
      sum = 9'(k) * 9'({a[3:1], 1'b0}) + {1'b0, c, 4'b0000};
      return sum[8] ? tcta_pkg::NIBBLE_MAX : sum[7:4];
   endfunction

   logic [tcta_pkg::NIBBLE_W-1:0] alpha;

   assign alpha = pixel[15:12];

   always_comb begin
      result.flagged  = pixel[tcta_pkg::FLAG_BIT];
      result.original = pixel;
      result.tinted   = {tcta_pkg::NIBBLE_MAX,
                         tint_nibble(tint.red,   alpha, pixel[11:8]),
                         tint_nibble(tint.green, alpha, pixel[7:4]),
                         tint_nibble(tint.blue,  alpha, pixel[3:0])};
      result.marked   = pixel;
      if (alpha != '0) begin
         result.marked[tcta_pkg::FLAG_BIT] = 1'b1;
      end
   end

endmodule

>>> design/tcta_merge.sv
// ----------------------------------------------------------------------------
// tcta_merge
// Combine lane results by the group flag and hold them in the output register.
// ----------------------------------------------------------------------------
module tcta_merge (
   input  logic                          clock,
   input  logic                          reset,
   input  tcta_pkg::lane_result_type     lane_res [tcta_pkg::LANES],
   input  logic                          last_group,
   input  logic                          in_valid,
   output logic                          in_ready,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [tcta_pkg::PIXEL_W-1:0]  out_pixel [tcta_pkg::LANES],
   output logic                          out_last
);

   logic                         any_flag;
   logic                         take;
   logic                         valid_ff, valid_in;
   logic [tcta_pkg::PIXEL_W-1:0] pixel_ff [tcta_pkg::LANES];
   logic [tcta_pkg::PIXEL_W-1:0] pixel_in [tcta_pkg::LANES];
   logic                         last_ff, last_in;

   always_comb begin
      any_flag = 1'b0;
      for (int i = 0; i < tcta_pkg::LANES; i++) begin
         any_flag = any_flag | lane_res[i].flagged;
      end
      for (int i = 0; i < tcta_pkg::LANES; i++) begin
         if (!any_flag) begin
            pixel_in[i] = lane_res[i].marked;
         end else if (lane_res[i].flagged) begin
            pixel_in[i] = lane_res[i].tinted;
         end else begin
            pixel_in[i] = lane_res[i].original;
         end
      end
      last_in = last_group;
   end

   // Accept a new beat whenever the register is empty or the held one leaves this cycle
   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         pixel_ff <= pixel_in;
         last_ff  <= last_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pixel = pixel_ff;
   assign out_last  = last_ff;

endmodule

>>> design/team_color_tint_argb4444_core.sv
// ----------------------------------------------------------------------------
// team_color_tint_argb4444_core
// Team color tint over groups of four ARGB4444 pixels.
// ----------------------------------------------------------------------------
// The result beat appears in the cycle after its request beat is accepted.
// Throughput: one pixel group per cycle while the result side is ready; the four lanes and the merge work in
// parallel and a single output register holds the result.
// Reset clears the tint registers to zero and empties the output register.
// Register writes are always accepted, one per cycle.
module team_color_tint_argb4444_core (
   input  logic       clock,
   input  logic       reset,
   tcta_req_if.sink   req_if,
   tcta_rsp_if.source rsp_if,
   tcta_csr_if.sink   csr_if
);

   tcta_pkg::tint_type           tint_ff, tint_in;
   logic [tcta_pkg::PIXEL_W-1:0] pixel [tcta_pkg::LANES];
   logic [tcta_pkg::PIXEL_W-1:0] out_pixel [tcta_pkg::LANES];
   tcta_pkg::lane_result_type    lane_res [tcta_pkg::LANES];

   assign csr_if.ready = 1'b1;

   always_comb begin
      tint_in = tint_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            tcta_pkg::CSR_TINT_RED:   tint_in.red   = csr_if.data;
            tcta_pkg::CSR_TINT_GREEN: tint_in.green = csr_if.data;
            tcta_pkg::CSR_TINT_BLUE:  tint_in.blue  = csr_if.data;
            default:                  tint_in       = tint_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tint_ff <= '0;
      end else begin
         tint_ff <= tint_in;
      end
   end

   assign pixel[0] = req_if.pixel0;
   assign pixel[1] = req_if.pixel1;
   assign pixel[2] = req_if.pixel2;
   assign pixel[3] = req_if.pixel3;

   for (genvar i = 0; i < tcta_pkg::LANES; i++) begin : g_lane
      tcta_lane u_lane (
         .pixel  (pixel[i]),
         .tint   (tint_ff),
         .result (lane_res[i])
      );
   end

   tcta_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .lane_res   (lane_res),
      .last_group (req_if.last_group),
      .in_valid   (req_if.valid),
      .in_ready   (req_if.ready),
      .out_valid  (rsp_if.valid),
      .out_ready  (rsp_if.ready),
      .out_pixel  (out_pixel),
      .out_last   (rsp_if.out_last)
   );

   assign rsp_if.out_pixel0 = out_pixel[0];
   assign rsp_if.out_pixel1 = out_pixel[1];
   assign rsp_if.out_pixel2 = out_pixel[2];
   assign rsp_if.out_pixel3 = out_pixel[3];

endmodule

>>> design/tcta_checker.sv
// ----------------------------------------------------------------------------
// tcta_checker
// Port-level checks of the team color tint core, bound to the top level.
// ----------------------------------------------------------------------------
`include "team_color_tint_argb4444_core_defines.svh"

module tcta_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [tcta_pkg::PIXEL_W-1:0] rsp_out_pixel0,
   input logic [tcta_pkg::PIXEL_W-1:0] rsp_out_pixel1,
   input logic [tcta_pkg::PIXEL_W-1:0] rsp_out_pixel2,
   input logic [tcta_pkg::PIXEL_W-1:0] rsp_out_pixel3
);

   logic alpha_any;
   logic flag_any;

   assign alpha_any = (rsp_out_pixel0[15:12] != '0) || (rsp_out_pixel1[15:12] != '0) ||
                      (rsp_out_pixel2[15:12] != '0) || (rsp_out_pixel3[15:12] != '0);
   assign flag_any  = rsp_out_pixel0[tcta_pkg::FLAG_BIT] || rsp_out_pixel1[tcta_pkg::FLAG_BIT] ||
                      rsp_out_pixel2[tcta_pkg::FLAG_BIT] || rsp_out_pixel3[tcta_pkg::FLAG_BIT];

   // Output register is empty right after reset
   `TCTA_ASSERT_ALWAYS(a_empty_after_reset, clock, reset |=> !rsp_valid, "rsp valid after reset")

   // Every accepted beat shows up as a result the next cycle
   `TCTA_ASSERT(a_accept_gives_rsp, clock, reset, (req_valid && req_ready) |=> rsp_valid,
      "accepted request beat produced no result")

   // An empty output stage never stalls the request side
   `TCTA_ASSERT(a_ready_when_empty, clock, reset, !rsp_valid |-> req_ready,
      "request stalled with empty output")

   // A group with any visible pixel always leaves with some flagged pixel
   `TCTA_ASSERT(a_flag_kept, clock, reset, (rsp_valid && alpha_any) |-> flag_any,
      "visible group left without a flagged pixel")

   // Stalled result beat stays valid and holds out_pixel0
   `TCTA_ASSERT(a_rsp_hold, clock, reset,
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_pixel0)),
      "stalled result beat changed")

endmodule

bind team_color_tint_argb4444_core tcta_checker u_tcta_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_out_pixel0 (rsp_if.out_pixel0),
   .rsp_out_pixel1 (rsp_if.out_pixel1),
   .rsp_out_pixel2 (rsp_if.out_pixel2),
   .rsp_out_pixel3 (rsp_if.out_pixel3)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Team color tint over groups of four ARGB4444 pixels. Directed groups hit
// the field extremes, single flagged lanes, unflagged groups and the
// saturating add. Random groups then run under several tint settings. The
// sender idles in bursts and the receiver stalls on its own pattern. Every
// result beat is compared lane by lane with a group predicted at acceptance.
// ----------------------------------------------------------------------------
module testbench;
   import tcta_pkg::*;

   localparam int CLOCK_PERIOD    = 10;
   localparam int RESET_CYCLES    = 8;
   localparam int IDLE_LIMIT      = 4000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASE_GROUPS    = 300;
   localparam int STALL_GROUPS    = 40;
   localparam int DRAIN_CYCLES    = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_UNUSED = 2'd3;
   localparam logic [PIXEL_W-1:0]     ALPHA_MASK       = 16'hF000;
   localparam logic [PIXEL_W-1:0]     FLAG_MASK        = 16'h1000;

   typedef struct packed {
      logic [LANES-1:0][PIXEL_W-1:0] pixel;
      logic                          last;
   } pixel_group_type;

   typedef enum logic [1:0] {
      RECV_ALWAYS,
      RECV_RANDOM,
      RECV_PATTERN
   } recv_mode_type;

   logic clock;
   logic reset;

   tcta_req_if req_bus();
   tcta_rsp_if rsp_bus();
   tcta_csr_if csr_bus();

   tint_type        tint_model;
   pixel_group_type expected_groups[$];
   pixel_group_type accepted_group;
   pixel_group_type result_group;
   pixel_group_type predicted_group;
   int              error_count      = 0;
   int              burst_left       = 4;
   bit              gaps_on          = 1'b1;
   recv_mode_type   recv_mode        = RECV_ALWAYS;
   int              hold_off_request = 0;

   team_color_tint_argb4444_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Tint prediction
   // ------------------------------------------------------------------------
   function automatic logic [NIBBLE_W-1:0] tint_nibble(logic [NIBBLE_W-1:0] team,
                                                       logic [NIBBLE_W-1:0] alpha,
                                                       logic [NIBBLE_W-1:0] color);
      int sum;
      sum = int'(team) * int'(alpha & 4'hE) + int'(color) * 16;
      if (sum > 255) sum = 255;
      return NIBBLE_W'(sum >> 4);
   endfunction

   function automatic logic [PIXEL_W-1:0] tint_pixel(tint_type tint, logic [PIXEL_W-1:0] p);
      logic [NIBBLE_W-1:0] alpha;
      alpha = p[15:12];
      return {NIBBLE_MAX,
              tint_nibble(tint.red, alpha, p[11:8]),
              tint_nibble(tint.green, alpha, p[7:4]),
              tint_nibble(tint.blue, alpha, p[3:0])};
   endfunction

   function automatic pixel_group_type tint_group(tint_type tint, pixel_group_type g);
      pixel_group_type r;
      logic            any_flagged;
      any_flagged = 1'b0;
      for (int i = 0; i < LANES; i++) any_flagged |= g.pixel[i][FLAG_BIT];
      r = g;
      for (int i = 0; i < LANES; i++) begin
         if (any_flagged) begin
            if (g.pixel[i][FLAG_BIT]) r.pixel[i] = tint_pixel(tint, g.pixel[i]);
         end else if ((g.pixel[i] & ALPHA_MASK) != '0) begin
            r.pixel[i] = g.pixel[i] | FLAG_MASK;
         end
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Monitors and result check
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         tint_model = '0;
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            CSR_TINT_RED:   tint_model.red   = csr_bus.data;
            CSR_TINT_GREEN: tint_model.green = csr_bus.data;
            CSR_TINT_BLUE:  tint_model.blue  = csr_bus.data;
            default: ;  // drop writes to unmapped indexes
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         accepted_group.pixel = {req_bus.pixel3, req_bus.pixel2, req_bus.pixel1, req_bus.pixel0};
         accepted_group.last  = req_bus.last_group;
         expected_groups.push_back(tint_group(tint_model, accepted_group));
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         result_group.pixel = {rsp_bus.out_pixel3, rsp_bus.out_pixel2,
                               rsp_bus.out_pixel1, rsp_bus.out_pixel0};
         result_group.last  = rsp_bus.out_last;
         if (expected_groups.size() == 0) begin
            $error("unexpected result beat: out_pixel0 %h out_last %b",
                   result_group.pixel[0], result_group.last);
            error_count++;
         end else begin
            predicted_group = expected_groups.pop_front();
            for (int i = 0; i < LANES; i++) begin
               if (result_group.pixel[i] !== predicted_group.pixel[i]) begin
                  $error("out_pixel%0d: expected %h, actual %h",
                         i, predicted_group.pixel[i], result_group.pixel[i]);
                  error_count++;
               end
            end
            if (result_group.last !== predicted_group.last) begin
               $error("out_last: expected %b, actual %b",
                      predicted_group.last, result_group.last);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: stall pattern plus an optional long hold-off
   // ------------------------------------------------------------------------
   initial begin
      int hold_left;
      int phase;
      hold_left = 0;
      phase     = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request > 0) begin
            hold_left        = hold_off_request;
            hold_off_request = 0;
         end
         phase = (phase + 1) % 7;
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            case (recv_mode)
               RECV_ALWAYS:  rsp_bus.ready <= 1'b1;
               RECV_RANDOM:  rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               RECV_PATTERN: rsp_bus.ready <= (phase < 4);
               default:      rsp_bus.ready <= 1'b1;
            endcase
         end
      end
   end

   // End the run when no channel has moved a beat for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
             || (csr_bus.valid && csr_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("team_color_tint_argb4444_core test failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------
   task automatic send_group(pixel_group_type g);
      int gap;
      req_bus.valid      <= 1'b1;
      req_bus.pixel0     <= g.pixel[0];
      req_bus.pixel1     <= g.pixel[1];
      req_bus.pixel2     <= g.pixel[2];
      req_bus.pixel3     <= g.pixel[3];
      req_bus.last_group <= g.last;
      do @(posedge clock); while (!req_bus.ready);
      if (gaps_on) begin
         burst_left--;
         if (burst_left <= 0) begin
            gap = $urandom_range(1, 6);
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
            burst_left = $urandom_range(1, 16);
         end
      end
   endtask

   task automatic send_lanes(logic [PIXEL_W-1:0] p0, logic [PIXEL_W-1:0] p1,
                             logic [PIXEL_W-1:0] p2, logic [PIXEL_W-1:0] p3, logic last);
      pixel_group_type g;
      g.pixel = {p3, p2, p1, p0};
      g.last  = last;
      send_group(g);
   endtask

   // Hold the input low until every predicted group has come back.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_groups.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] index, logic [NIBBLE_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   task automatic csr_idle();
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_tint(logic [NIBBLE_W-1:0] red, logic [NIBBLE_W-1:0] green,
                               logic [NIBBLE_W-1:0] blue);
      wait_idle();
      write_register(CSR_TINT_RED, red);
      write_register(CSR_TINT_GREEN, green);
      write_register(CSR_TINT_BLUE, blue);
      csr_idle();
   endtask

   function automatic logic [PIXEL_W-1:0] random_pixel(bit flagged);
      logic [PIXEL_W-1:0] p;
      p           = PIXEL_W'($urandom);
      p[FLAG_BIT] = flagged;
      if (!flagged && $urandom_range(0, 3) == 0) p[15:12] = '0;
      return p;
   endfunction

   // Mix fully random groups, unflagged groups and groups with a flagged lane.
   function automatic pixel_group_type random_group();
      pixel_group_type g;
      int              kind;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < LANES; i++) begin
         if (kind < 4)      g.pixel[i] = PIXEL_W'($urandom);
         else if (kind < 7) g.pixel[i] = random_pixel(1'b0);
         else               g.pixel[i] = random_pixel($urandom_range(0, 1));
      end
      if (kind >= 7) g.pixel[$urandom_range(0, LANES - 1)][FLAG_BIT] = 1'b1;
      g.last = ($urandom_range(0, 15) == 0);
      return g;
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_tint_registers();
      // tint is zero after reset: flagged pixels keep color, alpha goes to 15
      send_lanes(16'hF123, 16'h1ABC, 16'h0FFF, 16'hE456, 1'b1);
      wait_idle();
      // back-to-back writes to one register, then a write to an unmapped index
      write_register(CSR_TINT_RED, 4'h7);
      write_register(CSR_TINT_RED, 4'hF);
      write_register(CSR_INDEX_UNUSED, 4'hF);
      csr_idle();
      send_lanes(16'hF000, 16'h3000, 16'h1000, 16'hB000, 1'b0);
      program_tint(4'h0, 4'hF, 4'h0);
      send_lanes(16'hF000, 16'h5555, 16'h1AAA, 16'hD000, 1'b0);
      program_tint(4'h0, 4'h0, 4'hF);
      send_lanes(16'hF000, 16'h7777, 16'h9999, 16'h1000, 1'b1);
   endtask

   task automatic test_directed_groups();
      pixel_group_type g;
      program_tint(4'hF, 4'hF, 4'hF);
      send_lanes(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_lanes(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      // one flagged lane at a time, the rest unflagged with nonzero alpha
      for (int i = 0; i < LANES; i++) begin
         g.pixel    = {LANES{16'hE000}};
         g.pixel[i] = 16'hF000;
         g.last     = 1'b0;
         send_group(g);
      end
      // first group has no flagged lane: nonzero alpha gains the flag, zero alpha stays; the second has flagged lanes
      send_lanes(16'h0ABC, 16'h2ABC, 16'hE123, 16'h0000, 1'b0);
      send_lanes(16'h1000, 16'h2345, 16'h1FFF, 16'h0001, 1'b1);
      // saturation boundary on red: sums of 224, 240 and 256
      program_tint(4'h8, 4'h1, 4'h0);
      send_lanes(16'hF987, 16'hF800, 16'hF700, 16'h1F0F, 1'b0);
      program_tint(4'hF, 4'h8, 4'h1);
      send_lanes(16'hFFFF, 16'h3F0F, 16'h1888, 16'hF000, 1'b1);
   endtask

   task automatic test_input_stall();
      program_tint(4'h5, 4'hA, 4'h3);
      recv_mode        = RECV_ALWAYS;
      gaps_on          = 1'b0;
      hold_off_request = HOLD_OFF_CYCLES;
      // keep offering while the receiver holds off so the input stalls
      for (int i = 0; i < STALL_GROUPS; i++) send_group(random_group());
      gaps_on = 1'b1;
   endtask

   task automatic test_random_groups();
      tint_type tint;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       tint = '0;
            1:       tint = {NIBBLE_MAX, NIBBLE_MAX, NIBBLE_MAX};
            2:       tint = {NIBBLE_MAX, 4'h0, 4'h8};
            default: tint = tint_type'($urandom);
         endcase
         program_tint(tint.red, tint.green, tint.blue);
         recv_mode = recv_mode_type'(phase % 3);
         gaps_on   = (phase != 3);
         for (int i = 0; i < PHASE_GROUPS; i++) send_group(random_group());
      end
      recv_mode = RECV_ALWAYS;
   endtask

   initial begin
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.pixel0     <= '0;
      req_bus.pixel1     <= '0;
      req_bus.pixel2     <= '0;
      req_bus.pixel3     <= '0;
      req_bus.last_group <= 1'b0;
      csr_bus.valid      <= 1'b0;
      csr_bus.index      <= '0;
      csr_bus.data       <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_tint_registers();
      test_directed_groups();
      test_input_stall();
      test_random_groups();
      wait_idle();

      if (error_count == 0)
         $display("team_color_tint_argb4444_core test passed");
      else
         $display("team_color_tint_argb4444_core test failed");
      $finish;
   end

endmodule

>>> team_color_tint_argb4444_core.f
+incdir+design
design/tcta_pkg.sv
design/tcta_if.sv
design/tcta_lane.sv
design/tcta_merge.sv
design/team_color_tint_argb4444_core.sv
design/tcta_checker.sv
tb/testbench.sv
